// ===== hw/rtl/hka_pkg.sv =====
// Shared types and constants for the hall key actuation block.
// No dependencies.
`default_nettype none
package hka_pkg;
  localparam int KEY_COUNT = 3;
  localparam int KEY_BITS = 2;
  localparam int SAMPLE_BITS = 12;
  localparam int LEVEL_FRAC_BITS = 16;
  localparam int LEVEL_BITS = LEVEL_FRAC_BITS + 1;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 36;
  localparam int STATE_BITS = 28 + 18 + 7 + 17 + 1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = LEVEL_BITS'(1) << LEVEL_FRAC_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FILTER = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PRESS = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAL0 = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAL1 = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAL2 = 3'd7;

  localparam logic [1:0] MODE_FIXED = 2'd0;
  localparam logic [1:0] MODE_HYST = 2'd1;
  localparam logic [1:0] MODE_RAPID = 2'd2;
  localparam logic [1:0] FILT_OFF = 2'd0;
  localparam logic [1:0] FILT_OVS = 2'd1;
  localparam logic [1:0] FILT_EMA = 2'd2;

  typedef struct packed {
    logic [KEY_BITS-1:0] channel;
    logic [SAMPLE_BITS-1:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key_index;
    logic [LEVEL_BITS-1:0] key_level;
    logic is_pressed;
    logic press_edge;
    logic state_changed;
  } out_item_t;

  typedef struct packed {
    logic [27:0] ema_value;
    logic [17:0] ovs_sum;
    logic [6:0] ovs_count;
    logic [16:0] window_foot;
    logic key_pressed;
  } key_state_t;

  typedef struct packed {
    logic start;
    logic [16:0] upper;
    logic [17:0] dividend;
    logic [16:0] divisor;
  } div_req_t;
endpackage
`default_nettype wire

// ===== hw/rtl/hka_state_ram.sv =====
// Per-key state memory, one synchronous read and one write port.
// Depends on hka_pkg.
`default_nettype none
module hka_state_ram (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [hka_pkg::KEY_BITS-1:0] waddr,
  input  wire hka_pkg::key_state_t wdata,
  input  wire logic [hka_pkg::KEY_BITS-1:0] raddr,
  output hka_pkg::key_state_t rdata
);
  import hka_pkg::*;
  key_state_t mem [KEY_COUNT];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/hka_divider.sv =====
// Restoring divider, one quotient bit per cycle, 18-bit quotient.
// Depends on hka_pkg.
`default_nettype none
module hka_divider (
  input  wire logic clk,
  input  wire logic rst,
  input  wire hka_pkg::div_req_t req,
  output logic done,
  output logic [17:0] quotient
);
  import hka_pkg::*;
  logic [17:0] rem;
  logic [17:0] q;
  logic [16:0] dv;
  logic [4:0] cnt;
  logic busy;
  logic [18:0] trial;
  assign trial = {rem, q[17]} - {2'b0, dv};
  assign quotient = q;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem <= {1'b0, req.upper};
        q <= req.dividend;
        dv <= req.divisor;
        cnt <= 5'd17;
      end else if (busy) begin
        if (!trial[18]) begin
          rem <= trial[17:0];
          q <= {q[16:0], 1'b1};
        end else begin
          rem <= {rem[16:0], q[17]};
          q <= {q[16:0], 1'b0};
        end
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 5'd1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/hall_key_actuation_top.sv =====
// Hall key actuation: filter, normalize and actuate one key sample per transfer.
// Steps: read per-key state, filter (off, moving average, or oversample average by serial
// division), normalize (calibration scaling by serial division), actuate, output.
// One sample in flight; the next is taken the cycle after its result is loaded, and
// loading waits while an earlier result is stalled. A sample held by oversampling yields no result.
// Reset (rst, synchronous) restores register defaults, then a clearing pass
// zeroes per-key state. Depends on hka_pkg, hka_state_ram, hka_divider.
`default_nettype none
module hall_key_actuation_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire hka_pkg::in_item_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output hka_pkg::out_item_t out_data,
  input  wire logic cfg_we,
  input  wire logic [hka_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [hka_pkg::CFG_DATA_BITS-1:0] cfg_value
);
  import hka_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_FILT, S_EMA, S_OVSDIV, S_NORM, S_CALDIV, S_ACT, S_OUT
  } st_t;

  st_t st;
  logic [1:0] handler_mode;
  logic [23:0] filter_setup;
  logic [16:0] press_level, release_level, window_size;
  logic [35:0] key_cal [KEY_COUNT];

  logic [KEY_BITS-1:0] key;
  logic [SAMPLE_BITS-1:0] raw;
  key_state_t ks;
  key_state_t rd;
  key_state_t rd_clr;
  logic we;
  key_state_t wdata;
  logic [KEY_BITS-1:0] raddr;
  logic [SAMPLE_BITS-1:0] x;
  logic [16:0] level;
  logic signed [14:0] num, den;
  div_req_t dreq;
  logic ddone;
  logic [17:0] dq;

  hka_state_ram u_ram (.clk(clk), .we(we), .waddr(key), .wdata(wdata),
    .raddr(raddr), .rdata(rd));
  hka_divider u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quotient(dq));

  assign raddr = key;
  assign in_stall = (st != S_IDLE);

  // filter arithmetic
  logic [27:0] xq;
  logic [28:0] dif;
  logic [44:0] prod;
  logic [27:0] ema_n;
  logic [17:0] sum_n;
  logic [6:0] cnt_n;
  logic [6:0] ovs_n;
  assign xq = {raw, 16'd0};
  assign dif = (xq >= rd.ema_value) ? {1'b0, xq - rd.ema_value} : {1'b0, rd.ema_value - xq};
  assign ema_n = (xq >= rd.ema_value) ? rd.ema_value + prod[43:16] : rd.ema_value - prod[43:16];
  assign sum_n = rd.ovs_sum + 18'(raw);
  assign cnt_n = rd.ovs_count + 7'd1;
  assign ovs_n = {1'b0, filter_setup[7:2]} + 7'd1;

  always_comb begin
    rd_clr = rd;
    rd_clr.ovs_sum = '0;
    rd_clr.ovs_count = '0;
  end

  // normalization inputs
  logic [35:0] cal;
  logic signed [14:0] cmin, cmax, cdz;
  assign cal = key_cal[key];
  assign cmin = 15'(cal[11:0]);
  assign cmax = 15'(cal[23:12]);
  assign cdz = 15'(cal[35:24]);
  assign num = 15'(x) - cmin - cdz;
  assign den = cmax - cmin - (cdz <<< 1);

  always_comb begin
    dreq = '0;
    if (st == S_FILT && filter_setup[1:0] == FILT_OVS && cnt_n >= ovs_n) begin
      dreq.start = 1'b1;
      dreq.dividend = sum_n;
      dreq.divisor = 17'(cnt_n);
    end else if (st == S_NORM && den > 0 && num > 0 && num < den) begin
      dreq.start = 1'b1;
      dreq.upper = 17'(num[13:2]);
      dreq.dividend = {num[1:0], 16'd0};
      dreq.divisor = 17'(den);
    end
  end

  // actuation
  logic [17:0] foot_hi;
  logic now;
  logic [16:0] foot;
  always_comb begin
    foot_hi = 18'(ks.window_foot) + 18'(window_size);
    now = ks.key_pressed;
    foot = ks.window_foot;
    case (handler_mode)
      MODE_HYST: begin
        if (level > press_level) now = 1'b1;
        else if (level < release_level) now = 1'b0;
      end
      MODE_RAPID: begin
        if (18'(level) > foot_hi) begin
          now = 1'b1;
          foot = level - window_size;
        end else if (level < ks.window_foot) begin
          now = 1'b0;
          foot = level;
        end
        if (level == 17'd0) foot = 17'd0;
        if (level == LEVEL_ONE) foot = (window_size > LEVEL_ONE) ? 17'd0 : LEVEL_ONE - window_size;
      end
      default: now = level > press_level;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wdata = ks;
    if (st == S_CLEAR) begin
      we = 1'b1;
      wdata = '0;
    end else if (st == S_ACT) begin
      we = 1'b1;
      wdata.key_pressed = now;
      if (handler_mode == MODE_RAPID) wdata.window_foot = foot;
    end else if (st == S_FILT && filter_setup[1:0] == FILT_OVS && cnt_n < ovs_n) begin
      we = 1'b1;
      wdata = rd;
      wdata.ovs_sum = sum_n;
      wdata.ovs_count = cnt_n;
    end
  end

  always_ff @(posedge clk) begin
    prod <= 45'(dif) * 45'(filter_setup[23:8]);
    if (rst) begin
      st <= S_CLEAR;
      key <= '0;
      out_valid <= 1'b0;
      handler_mode <= '0;
      filter_setup <= '0;
      press_level <= 17'd32768;
      release_level <= 17'd16384;
      window_size <= 17'd6554;
      for (int i = 0; i < KEY_COUNT; i++) key_cal[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE: handler_mode <= cfg_value[1:0];
          REG_FILTER: filter_setup <= cfg_value[23:0];
          REG_PRESS: press_level <= cfg_value[16:0];
          REG_RELEASE: release_level <= cfg_value[16:0];
          REG_WINDOW: window_size <= cfg_value[16:0];
          REG_CAL0: key_cal[0] <= cfg_value;
          REG_CAL1: key_cal[1] <= cfg_value;
          REG_CAL2: key_cal[2] <= cfg_value;
          default: ;
        endcase
      end
      if (st == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (st)
        S_CLEAR: begin
          if (32'(key) == KEY_COUNT - 1) begin
            st <= S_IDLE;
          end else key <= key + 1'b1;
        end
        S_IDLE: begin
          if (in_valid && 32'(in_data.channel) < KEY_COUNT) begin
            key <= in_data.channel;
            raw <= in_data.raw_sample;
            st <= S_READ;
          end
        end
        S_READ: st <= S_FILT;
        S_FILT: begin
          case (filter_setup[1:0])
            FILT_OFF: begin
              ks <= rd;
              x <= raw;
              st <= S_NORM;
            end
            FILT_OVS: begin
              if (cnt_n < ovs_n) st <= S_IDLE;
              else begin
                ks <= rd_clr;
                st <= S_OVSDIV;
              end
            end
            default: begin
              ks <= rd;
              st <= S_EMA;
            end
          endcase
        end
        S_EMA: begin
          ks.ema_value <= ema_n;
          x <= ema_n[27:16];
          st <= S_NORM;
        end
        S_OVSDIV: begin
          if (ddone) begin
            x <= dq[11:0];
            st <= S_NORM;
          end
        end
        S_NORM: begin
          if (den <= 0) begin
            level <= (num > 0) ? LEVEL_ONE : 17'd0;
            st <= S_ACT;
          end else if (num <= 0) begin
            level <= 17'd0;
            st <= S_ACT;
          end else if (num >= den) begin
            level <= LEVEL_ONE;
            st <= S_ACT;
          end else begin
            st <= S_CALDIV;
          end
        end
        S_CALDIV: begin
          if (ddone) begin
            level <= dq[16:0];
            st <= S_ACT;
          end
        end
        S_ACT: st <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_data.key_index <= key;
            out_data.key_level <= level;
            out_data.is_pressed <= now;
            out_data.press_edge <= now & ~ks.key_pressed;
            out_data.state_changed <= now ^ ks.key_pressed;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
